### design/urb_pkg.sv
// Shared types and constants for the serial-port receive and transmit ring buffers.
package urb_pkg;

   typedef enum logic [1:0] {
      OP_LINE_BYTE = 2'd0,
      OP_HOST_GET  = 2'd1,
      OP_HOST_PUT  = 2'd2,
      OP_TX_READY  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_RX   = 2'd1,
      SRC_TX   = 2'd2
   } data_src_type;

   localparam logic [2:0] ERR_NONE          = 3'd0;
   localparam logic [2:0] ERR_RING_OVERFLOW = 3'd4;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  data_byte;
      logic        frame_error;
      logic        data_overrun;
      logic        shifter_busy;
   } req_type;

   typedef struct packed {
      logic [7:0]  data_out;
      logic        data_valid;
      logic        put_accepted;
      logic        rx_data_ready;
      logic        tx_busy;
      logic [2:0]  rx_error;
      logic        tx_irq_enable;
   } rsp_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic last_one;
   } ring_status_type;

endpackage

### design/urb_stream_if.sv
// Valid and ready channel that carries one payload per transaction.
interface urb_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### design/uart_rx_tx_ring_buffers_core.sv
// Top level of the serial-port ring buffers: receive and transmit rings with host access.
//
// Each request is one of four operations: a received line byte, a host get, a host put
// or a transmitter-ready event. Every request yields exactly one response. A request is
// taken only while none is pending; on that edge the ring memory is read and the request's
// status is registered in the pending stage, from which the response moves into the output
// register once that register is empty or being taken. A new request waits until the
// pending one has moved on, but is accepted while a finished response still waits.
// Each ring holds one entry less than its depth. Ring memories need no clearing pass.
module uart_rx_tx_ring_buffers_core #(
   parameter int RX_DEPTH = 256,
   parameter int TX_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   urb_stream_if.sink   req_chan,
   urb_stream_if.source rsp_chan
);
   import urb_pkg::*;

   req_type         req;
   logic            req_accept;
   logic            out_load;
   ring_status_type rx_stat;
   ring_status_type tx_stat;
   logic [7:0]      rx_rd_data;
   logic [7:0]      tx_rd_data;
   logic            rx_push;
   logic            rx_pop;
   logic            tx_push;
   logic            tx_pop;

   logic            pend_ff;
   logic            pend_in;
   data_src_type    pend_src_ff;
   data_src_type    pend_src_in;
   rsp_type         pend_rsp_ff;
   rsp_type         pend_rsp_in;
   logic [2:0]      last_error_ff;
   logic [2:0]      last_error_in;
   logic            tx_irq_ff;
   logic            tx_irq_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;

   assign req        = req_chan.payload;
   assign req_chan.ready = !pend_ff;
   assign req_accept = req_chan.valid && !pend_ff;
   assign out_load   = pend_ff && (!rsp_valid_ff || rsp_chan.ready);

   urb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
      .clock     (clock),
      .reset     (reset),
      .push      (rx_push),
      .push_data (req.data_byte),
      .pop       (rx_pop),
      .stat      (rx_stat),
      .rd_data   (rx_rd_data)
   );

   urb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
      .clock     (clock),
      .reset     (reset),
      .push      (tx_push),
      .push_data (req.data_byte),
      .pop       (tx_pop),
      .stat      (tx_stat),
      .rd_data   (tx_rd_data)
   );

   always_comb begin
      rx_push       = 1'b0;
      rx_pop        = 1'b0;
      tx_push       = 1'b0;
      tx_pop        = 1'b0;
      last_error_in = last_error_ff;
      tx_irq_in     = tx_irq_ff;
      pend_src_in   = SRC_NONE;
      pend_rsp_in   = '0;
      pend_rsp_in.rx_data_ready = !rx_stat.empty;
      pend_rsp_in.tx_busy       = !tx_stat.empty;
      unique case (req.opcode)
         OP_LINE_BYTE: begin
            pend_rsp_in.rx_data_ready = 1'b1;
            if (rx_stat.full) begin
               last_error_in = ERR_RING_OVERFLOW;
            end else begin
               rx_push       = req_accept;
               last_error_in = {1'b0, req.data_overrun, req.frame_error};
            end
         end
         OP_HOST_GET: begin
            if (!rx_stat.empty) begin
               rx_pop                    = req_accept;
               pend_src_in               = SRC_RX;
               pend_rsp_in.data_valid    = 1'b1;
               pend_rsp_in.rx_data_ready = !rx_stat.last_one;
            end
         end
         OP_HOST_PUT: begin
            pend_rsp_in.tx_busy = 1'b1;
            if (!tx_stat.full) begin
               tx_push                  = req_accept;
               tx_irq_in                = 1'b1;
               pend_rsp_in.put_accepted = 1'b1;
            end
         end
         OP_TX_READY: begin
            if (!tx_stat.empty) begin
               tx_pop                 = req_accept;
               pend_src_in            = SRC_TX;
               pend_rsp_in.data_valid = 1'b1;
               pend_rsp_in.tx_busy    = !tx_stat.last_one;
            end else begin
               tx_irq_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
      pend_rsp_in.tx_busy       = pend_rsp_in.tx_busy || req.shifter_busy;
      pend_rsp_in.rx_error      = last_error_in;
      pend_rsp_in.tx_irq_enable = tx_irq_in;
   end

   always_comb begin
      pend_in      = req_accept || (pend_ff && !out_load);
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_chan.ready);
      rsp_in       = pend_rsp_ff;
      unique case (pend_src_ff)
         SRC_RX:   rsp_in.data_out = rx_rd_data;
         SRC_TX:   rsp_in.data_out = tx_rd_data;
         default:  rsp_in.data_out = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_error_ff <= ERR_NONE;
         tx_irq_ff     <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            last_error_ff <= last_error_in;
            tx_irq_ff     <= tx_irq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pend_src_ff <= pend_src_in;
         pend_rsp_ff <= pend_rsp_in;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   a_get_reads_rx : assert property (@(posedge clock) disable iff (reset)
      req_accept && (req.opcode == OP_HOST_GET) && !rx_stat.empty
      |=> pend_ff && (pend_src_ff == SRC_RX))
      else $error("Host get on a non-empty receive ring did not select receive data.");

   a_put_sets_irq : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.put_accepted |-> rsp_ff.tx_irq_enable && rsp_ff.tx_busy)
      else $error("Accepted put without transmit interrupt enable or busy status.");

   a_single_ring_op : assert property (@(posedge clock) disable iff (reset)
      !(rx_push && rx_pop) && !(tx_push && tx_pop) && !(rx_pop && tx_pop))
      else $error("Conflicting ring operations in one transaction.");

endmodule

### design/urb_ring.sv
// One ring buffer: head and tail pointers around a synchronous memory with registered read.
module urb_ring #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [7:0]               push_data,
   input  logic                     pop,
   output urb_pkg::ring_status_type stat,
   output logic [7:0]               rd_data
);
   import urb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [PTR_W-1:0] head_ff;
   logic [PTR_W-1:0] head_in;
   logic [PTR_W-1:0] tail_ff;
   logic [PTR_W-1:0] tail_in;
   logic [PTR_W-1:0] head_next;
   logic [PTR_W-1:0] tail_next;
   logic [7:0]       rd_data_ff;
   logic [7:0]       mem [DEPTH];

   assign head_next = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;

   assign stat.empty    = (head_ff == tail_ff);
   assign stat.full     = (head_next == tail_ff);
   assign stat.last_one = (tail_next == head_ff);

   always_comb begin
      head_in = push ? head_next : head_ff;
      tail_in = pop ? tail_next : tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[head_next] <= push_data;
      end
      if (pop) begin
         rd_data_ff <= mem[tail_next];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/testbench.sv
// Self-checking testbench for the serial-port receive and transmit ring buffers.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import urb_pkg::*;

   localparam int RX_DEPTH = 256;
   localparam int TX_DEPTH = 64;
   localparam int RANDOM_ITEMS = 1200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   urb_stream_if #(.payload_type(req_type)) req_if ();
   urb_stream_if #(.payload_type(rsp_type)) rsp_if ();

   uart_rx_tx_ring_buffers_core #(
      .RX_DEPTH(RX_DEPTH),
      .TX_DEPTH(TX_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   always #1 clock = ~clock;

   req_type pending_reqs[$];
   rsp_type expected_responses[$];
   int total_items = 0;
   int requests_accepted = 0;
   int failures = 0;

   logic [7:0] rx_bytes [RX_DEPTH];
   logic [7:0] tx_bytes [TX_DEPTH];
   int rx_wr = 0;
   int rx_rd = 0;
   int tx_wr = 0;
   int tx_rd = 0;
   logic [2:0] rx_err_state = ERR_NONE;
   logic tx_irq_state = 1'b0;

   int rx_overflows = 0;
   int rejected_puts = 0;
   int empty_gets = 0;
   int idle_tx_polls = 0;

   int burst_left = 0;
   int gap_left = 0;
   int rsp_cycle = 0;
   int stall_mode = 0;
   int hold_left = 0;

   function automatic int ring_advance(int ptr, int depth);
      return (ptr + 1 >= depth) ? 0 : ptr + 1;
   endfunction

   function automatic rsp_type predict_ring_response(req_type r);
      rsp_type p;
      int nxt;
      p = '0;
      case (r.opcode)
         OP_LINE_BYTE: begin
            nxt = ring_advance(rx_wr, RX_DEPTH);
            if (nxt == rx_rd) begin
               rx_err_state = ERR_RING_OVERFLOW;
               rx_overflows++;
            end else begin
               rx_wr = nxt;
               rx_bytes[nxt] = r.data_byte;
               rx_err_state = {1'b0, r.data_overrun, r.frame_error};
            end
         end
         OP_HOST_GET: begin
            if (rx_wr != rx_rd) begin
               rx_rd = ring_advance(rx_rd, RX_DEPTH);
               p.data_out = rx_bytes[rx_rd];
               p.data_valid = 1'b1;
            end else begin
               empty_gets++;
            end
         end
         OP_HOST_PUT: begin
            nxt = ring_advance(tx_wr, TX_DEPTH);
            if (nxt != tx_rd) begin
               tx_bytes[nxt] = r.data_byte;
               tx_wr = nxt;
               tx_irq_state = 1'b1;
               p.put_accepted = 1'b1;
            end else begin
               rejected_puts++;
            end
         end
         default: begin
            if (tx_wr != tx_rd) begin
               tx_rd = ring_advance(tx_rd, TX_DEPTH);
               p.data_out = tx_bytes[tx_rd];
               p.data_valid = 1'b1;
            end else begin
               tx_irq_state = 1'b0;
               idle_tx_polls++;
            end
         end
      endcase
      p.rx_data_ready = (rx_wr != rx_rd);
      p.tx_busy = (tx_wr != tx_rd) || r.shifter_busy;
      p.rx_error = rx_err_state;
      p.tx_irq_enable = tx_irq_state;
      return p;
   endfunction

   task automatic queue_request(opcode_type op, logic [7:0] data, logic fe, logic dor,
                                logic busy);
      req_type r;
      r.opcode = op;
      r.data_byte = data;
      r.frame_error = fe;
      r.data_overrun = dor;
      r.shifter_busy = busy;
      pending_reqs.push_back(r);
   endtask

   function automatic opcode_type pick_opcode(opcode_type favored, int favor_pct);
      if ($urandom_range(99) < favor_pct) return favored;
      return opcode_type'($urandom_range(3));
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_if.valid <= 1'b1;
            req_if.payload <= pending_reqs.pop_front();
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_cycle++;
         if (rsp_cycle % 64 == 0) stall_mode = $urandom_range(3);
         if (rsp_cycle == 1000) hold_left = 400;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_if.ready <= 1'b1;
               1: rsp_if.ready <= 1'($urandom_range(1));
               2: rsp_if.ready <= (rsp_cycle % 3 == 0);
               default: rsp_if.ready <= ($urandom_range(99) < 85);
            endcase
         end
      end
   end

   always @(posedge clock) begin : transaction_monitor
      rsp_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_responses.size() == 0) begin
               $error("Response transaction arrived with no request outstanding");
               failures++;
            end else begin
               want = expected_responses.pop_front();
               check_field("data_out", want.data_out, rsp_if.payload.data_out);
               check_field("data_valid", want.data_valid, rsp_if.payload.data_valid);
               check_field("put_accepted", want.put_accepted, rsp_if.payload.put_accepted);
               check_field("rx_data_ready", want.rx_data_ready,
                           rsp_if.payload.rx_data_ready);
               check_field("tx_busy", want.tx_busy, rsp_if.payload.tx_busy);
               check_field("rx_error", want.rx_error, rsp_if.payload.rx_error);
               check_field("tx_irq_enable", want.tx_irq_enable,
                           rsp_if.payload.tx_irq_enable);
            end
         end
         if (req_if.valid && req_if.ready) begin
            expected_responses.push_back(predict_ring_response(req_if.payload));
            requests_accepted++;
         end
      end
   end

   initial begin
      int seg;
      int seg_len;
      int favor;
      int goal;
      opcode_type focus;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;

      // Short directed sequence over the field extremes and the empty-ring cases.
      queue_request(OP_HOST_GET, 8'h00, 1'b0, 1'b0, 1'b0);
      queue_request(OP_TX_READY, 8'h00, 1'b0, 1'b0, 1'b1);
      queue_request(OP_LINE_BYTE, 8'h00, 1'b0, 1'b0, 1'b0);
      queue_request(OP_LINE_BYTE, 8'hFF, 1'b1, 1'b1, 1'b1);
      queue_request(OP_LINE_BYTE, 8'hA5, 1'b1, 1'b0, 1'b0);
      queue_request(OP_LINE_BYTE, 8'h5A, 1'b0, 1'b1, 1'b0);
      queue_request(OP_HOST_GET, 8'hFF, 1'b1, 1'b1, 1'b1);
      queue_request(OP_HOST_GET, 8'h00, 1'b0, 1'b0, 1'b0);
      queue_request(OP_HOST_GET, 8'h00, 1'b0, 1'b0, 1'b1);
      queue_request(OP_HOST_GET, 8'h00, 1'b0, 1'b0, 1'b0);
      queue_request(OP_HOST_GET, 8'h00, 1'b0, 1'b0, 1'b0);
      queue_request(OP_HOST_PUT, 8'h00, 1'b0, 1'b0, 1'b0);
      queue_request(OP_HOST_PUT, 8'hFF, 1'b1, 1'b1, 1'b1);
      queue_request(OP_HOST_PUT, 8'h81, 1'b0, 1'b0, 1'b0);
      queue_request(OP_TX_READY, 8'hFF, 1'b1, 1'b1, 1'b0);
      queue_request(OP_TX_READY, 8'h00, 1'b0, 1'b0, 1'b1);
      queue_request(OP_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
      queue_request(OP_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
      queue_request(OP_TX_READY, 8'h00, 1'b0, 1'b0, 1'b1);

      // Random segments that alternately fill and drain each ring past its limits, plus a mixed one.
      goal = pending_reqs.size() + RANDOM_ITEMS;
      seg = 0;
      while (pending_reqs.size() < goal) begin
         case (seg % 5)
            0: begin
               focus = OP_LINE_BYTE;
               seg_len = $urandom_range(270, 330);
               favor = 95;
            end
            1: begin
               focus = OP_HOST_PUT;
               seg_len = $urandom_range(60, 100);
               favor = 92;
            end
            2: begin
               focus = OP_HOST_GET;
               seg_len = $urandom_range(250, 320);
               favor = 90;
            end
            3: begin
               focus = OP_TX_READY;
               seg_len = $urandom_range(60, 100);
               favor = 90;
            end
            default: begin
               focus = OP_LINE_BYTE;
               seg_len = $urandom_range(100, 200);
               favor = 0;
            end
         endcase
         for (int i = 0; i < seg_len && pending_reqs.size() < goal; i++) begin
            queue_request(pick_opcode(focus, favor), 8'($urandom_range(255)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
         end
         seg++;
      end
      total_items = pending_reqs.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (requests_accepted < total_items || expected_responses.size() != 0);
      repeat (8) @(negedge clock);
      if (expected_responses.size() != 0) begin
         $error("%0d responses never arrived", expected_responses.size());
         failures++;
      end

      $display("Checked %0d transactions, including %0d receive ring overflows and %0d puts",
               total_items, rx_overflows, rejected_puts);
      $display("rejected on a full transmit ring; %0d gets and %0d transmit polls hit empty rings.",
               empty_gets, idle_tx_polls);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #500000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

### sim.f
design/urb_pkg.sv
design/urb_stream_if.sv
design/urb_ring.sv
design/uart_rx_tx_ring_buffers_core.sv
tb/testbench.sv
